// ----- hdl/sha256_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package sha256_pkg;

  typedef enum logic [1:0] {
    SEL_DATA,
    SEL_MARK,
    SEL_ZERO,
    SEL_LEN
  } byte_sel_t;

  typedef struct packed {
    logic      push;
    byte_sel_t sel;
    logic      load_vars;
    logic      round_en;
    logic [5:0] round_idx;
    logic      add_hash;
    logic      init_hash;
    logic [2:0] out_idx;
  } cmd_t;

  typedef struct packed {
    logic [5:0] fill;
  } stat_t;

  localparam logic [7:0] PadMark = 8'h80;
  localparam logic [5:0] LengthPos = 6'd56;

  function automatic logic [31:0] init_value(input logic [2:0] i);
    logic [31:0] r;
    unique case (i)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
      32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
      32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
      32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
      32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
      32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
      32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
      32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
      32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
      32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
      32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
    return k[i];
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage
`default_nettype wire

// ----- hdl/sha256_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
module sha256_dp (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 [7:0] data_byte,
  input  sha256_pkg::cmd_t    cmd,
  output sha256_pkg::stat_t   stat,
  output logic [31:0]         digest_word
);

  logic [31:0] hash [8];
  logic [31:0] vars [8];
  logic [31:0] sched [16];
  logic [23:0] word_acc;
  logic [5:0]  fill;
  logic [63:0] bit_count;

  logic [7:0]  push_byte;
  logic [2:0]  len_idx;
  logic [31:0] new_w;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] ch;
  logic [31:0] maj;

  always_comb begin
    len_idx = fill[2:0];
    unique case (cmd.sel)
      sha256_pkg::SEL_DATA: push_byte = data_byte;
      sha256_pkg::SEL_MARK: push_byte = sha256_pkg::PadMark;
      sha256_pkg::SEL_ZERO: push_byte = 8'h00;
      default:              push_byte = bit_count[8*(7-len_idx) +: 8];
    endcase
  end

  always_comb begin
    new_w = sha256_pkg::small_sigma1(sched[14]) + sched[9] +
            sha256_pkg::small_sigma0(sched[1]) + sched[0];
    ch    = (vars[4] & vars[5]) ^ (~vars[4] & vars[6]);
    maj   = (vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]);
    t1    = vars[7] + sha256_pkg::big_sigma1(vars[4]) + ch +
            sha256_pkg::round_k(cmd.round_idx) + sched[0];
    t2    = sha256_pkg::big_sigma0(vars[0]) + maj;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      bit_count <= '0;
      for (int i = 0; i < 8; i++) begin
        hash[i] <= sha256_pkg::init_value(3'(i));
      end
    end else begin
      if (cmd.push) begin
        fill <= fill + 6'd1;
        if (cmd.sel == sha256_pkg::SEL_DATA) begin
          bit_count <= bit_count + 64'd8;
        end
      end
      if (cmd.add_hash) begin
        for (int i = 0; i < 8; i++) begin
          hash[i] <= hash[i] + vars[i];
        end
      end
      if (cmd.init_hash) begin
        bit_count <= '0;
        for (int i = 0; i < 8; i++) begin
          hash[i] <= sha256_pkg::init_value(3'(i));
        end
      end
    end
  end

  // message words and working variables carry no reset
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      if (fill[1:0] == 2'd3) begin
        for (int i = 0; i < 15; i++) begin
          sched[i] <= sched[i+1];
        end
        sched[15] <= {word_acc, push_byte};
      end else begin
        word_acc <= {word_acc[15:0], push_byte};
      end
    end else if (cmd.round_en) begin
      for (int i = 0; i < 15; i++) begin
        sched[i] <= sched[i+1];
      end
      sched[15] <= new_w;
    end
    if (cmd.load_vars) begin
      for (int i = 0; i < 8; i++) begin
        vars[i] <= hash[i];
      end
    end else if (cmd.round_en) begin
      vars[7] <= vars[6];
      vars[6] <= vars[5];
      vars[5] <= vars[4];
      vars[4] <= vars[3] + t1;
      vars[3] <= vars[2];
      vars[2] <= vars[1];
      vars[1] <= vars[0];
      vars[0] <= t1 + t2;
    end
  end

  assign stat.fill   = fill;
  assign digest_word = hash[cmd.out_idx];

endmodule
`default_nettype wire

// ----- hdl/sha256_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module sha256_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire                 byte_present,
  input  wire                 end_of_message,
  output logic                out_valid,
  input  wire                 out_stall,
  output logic                digest_last,
  input  sha256_pkg::stat_t   stat,
  output sha256_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } state_t;

  state_t     state;
  state_t     state_next;
  logic [5:0] round_cnt;
  logic [2:0] out_idx;
  logic       ending;
  logic       marked;
  logic       len_phase;
  logic       take;
  logic       push;
  logic       full;

  assign in_stall    = (state != ST_IDLE);
  assign take        = in_valid && !in_stall;
  assign digest_last = (out_idx == 3'd7);
  assign full        = push && (stat.fill == 6'd63);

  always_comb begin
    unique case (state)
      ST_IDLE: push = take && byte_present;
      ST_PAD:  push = 1'b1;
      default: push = 1'b0;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.push      = push;
    cmd.sel       = sha256_pkg::SEL_DATA;
    cmd.round_idx = round_cnt;
    cmd.out_idx   = out_idx;
    state_next    = state;
    unique case (state)
      ST_IDLE: begin
        if (full) begin
          state_next = ST_ROUND;
        end else if (take && end_of_message) begin
          state_next = ST_PAD;
        end
      end
      ST_PAD: begin
        priority if (!marked) begin
          cmd.sel = sha256_pkg::SEL_MARK;
        end else if (len_phase || stat.fill == sha256_pkg::LengthPos) begin
          cmd.sel = sha256_pkg::SEL_LEN;
        end else begin
          cmd.sel = sha256_pkg::SEL_ZERO;
        end
        if (full) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd.round_en = 1'b1;
        if (round_cnt == 6'd63) begin
          state_next = ST_ADD;
        end
      end
      ST_ADD: begin
        cmd.add_hash = 1'b1;
        priority if (ending && len_phase) begin
          state_next = ST_OUT;
        end else if (ending) begin
          state_next = ST_PAD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        if (!out_stall && digest_last) begin
          cmd.init_hash = 1'b1;
          state_next    = ST_IDLE;
        end
      end
    endcase
    cmd.load_vars = full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      round_cnt <= '0;
      out_idx   <= '0;
      ending    <= 1'b0;
      marked    <= 1'b0;
      len_phase <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_ROUND) begin
        round_cnt <= round_cnt + 6'd1;
      end
      if (take && end_of_message) begin
        ending <= 1'b1;
      end
      if (state == ST_PAD) begin
        if (!marked) begin
          marked <= 1'b1;
        end else if (cmd.sel == sha256_pkg::SEL_LEN) begin
          len_phase <= 1'b1;
        end
      end
      if (state == ST_ADD && state_next == ST_OUT) begin
        out_valid <= 1'b1;
        out_idx   <= '0;
      end
      if (state == ST_OUT && !out_stall) begin
        out_idx <= out_idx + 3'd1;
        if (digest_last) begin
          // drop message state for the next request
          out_valid <= 1'b0;
          ending    <= 1'b0;
          marked    <= 1'b0;
          len_phase <= 1'b0;
        end
      end
    end
  end

`ifndef ASSERT_OFF
  a_out_only_in_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state == ST_OUT))
    else $error("digest valid outside output phase");
  a_no_take_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("request taken while digest pending");
  a_round_cnt_wraps: assert property (@(posedge clk) disable iff (rst)
    (state != ST_ROUND) |-> (round_cnt == 6'd0))
    else $error("round counter left nonzero");
  a_len_after_mark: assert property (@(posedge clk) disable iff (rst)
    len_phase |-> (marked && ending))
    else $error("length phase without pad mark");
`endif

endmodule
`default_nettype wire

// ----- hdl/sha256_hash_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Channel  | Handshake           | Payload
// input    | in_valid, in_stall  | data_byte, byte_present, end_of_message
// output   | out_valid, out_stall| digest_word, digest_last
//
// Every 64th byte starts a block (64 rounds, one add).
// An end request pads one byte a cycle, one or two blocks, then holds 8 words.
// The shared round unit, one round per cycle, sets the rate.
// rst is synchronous; it restores the initial hash and clears the length.
// in_stall is high whenever a block or digest is in progress.
module sha256_hash_engine (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire [7:0]   data_byte,
  input  wire         byte_present,
  input  wire         end_of_message,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [31:0] digest_word,
  output logic        digest_last
);

  sha256_pkg::cmd_t  cmd;
  sha256_pkg::stat_t stat;

  sha256_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .byte_present   (byte_present),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .digest_last    (digest_last),
    .stat           (stat),
    .cmd            (cmd)
  );

  sha256_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .data_byte   (data_byte),
    .cmd         (cmd),
    .stat        (stat),
    .digest_word (digest_word)
  );

endmodule
`default_nettype wire
